// ===== sv/rgbhsl_pkg.sv =====
// Package: shared widths, constants and types of the RGB to HSL converter.
`timescale 1ns / 1ps
`default_nettype none

package rgbhsl_pkg;

   localparam int CHAN_W     = 8;   // one color channel
   localparam int HUE_W      = 15;  // hue in 1/64 degree
   localparam int FRAC_W     = 16;  // Q0.16 saturation and lightness
   localparam int SUM_W      = CHAN_W + 1;
   localparam int NUM_W      = 24;  // signed hue numerator before wrap
   localparam int HUE_DVD_W  = 23;  // hue numerator after wrap, below 23040*255
   localparam int SAT_DVD_W  = CHAN_W + FRAC_W;
   localparam int QUOT_W     = FRAC_W + 1;  // both quotients fit in 17 bits

   localparam logic [HUE_W-1:0]  HUE_MAX   = 15'd23039;
   localparam logic [FRAC_W-1:0] FRAC_MAX  = 16'hFFFF;
   localparam logic [SUM_W-1:0]  SUM_MID   = 9'd255;
   localparam logic [SUM_W-1:0]  SUM_TOP   = 9'd510;

   // hue numerator scale factors, all in 1/64 degree per unit of chroma
   localparam logic signed [NUM_W-1:0] HUE_SCALE     = 24'sd3840;   // 60 * 64
   localparam logic signed [NUM_W-1:0] HUE_OFS_GREEN = 24'sd7680;   // 120 * 64
   localparam logic signed [NUM_W-1:0] HUE_OFS_BLUE  = 24'sd15360;  // 240 * 64
   localparam logic signed [NUM_W-1:0] HUE_FULL      = 24'sd23040;  // 360 * 64

   typedef enum logic [2:0] {
      SECTOR_RED   = 3'b001,
      SECTOR_GREEN = 3'b010,
      SECTOR_BLUE  = 3'b100
   } sector_type;

   typedef struct packed {
      logic              grey;
      logic [FRAC_W-1:0] light;
   } side_type;

endpackage

`default_nettype wire

// ===== sv/rgbhsl_div.sv =====
// Module: pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_div #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 8,
   parameter int QUOT_W     = 17
) (
   input  logic                  clock,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [QUOT_W-1:0]     quotient
);

   // Caller guarantees dividend < divisor * 2**QUOT_W, so the head of the
   // dividend is already below the divisor and the remainder stays narrow.
   localparam int HEAD_W = DIVIDEND_W - QUOT_W;

   logic [DIVISOR_W-1:0] rem_src  [QUOT_W];
   logic [QUOT_W-1:0]    bits_src [QUOT_W];
   logic [DIVISOR_W-1:0] den_src  [QUOT_W];
   logic [DIVISOR_W:0]   trial    [QUOT_W];

   logic [DIVISOR_W-1:0] rem_in   [QUOT_W];
   logic [QUOT_W-1:0]    bits_in  [QUOT_W];
   logic [DIVISOR_W-1:0] den_in   [QUOT_W];
   logic [DIVISOR_W-1:0] rem_ff   [QUOT_W];
   logic [QUOT_W-1:0]    bits_ff  [QUOT_W];
   logic [DIVISOR_W-1:0] den_ff   [QUOT_W];

   for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
      if (i == 0) begin : g_first
         logic [HEAD_W-1:0] head;
         assign head        = dividend[DIVIDEND_W-1:QUOT_W];
         assign rem_src[i]  = DIVISOR_W'(head);
         assign bits_src[i] = dividend[QUOT_W-1:0];
         assign den_src[i]  = divisor;
      end else begin : g_next
         assign rem_src[i]  = rem_ff[i-1];
         assign bits_src[i] = bits_ff[i-1];
         assign den_src[i]  = den_ff[i-1];
      end

      // shift in the next dividend bit, subtract when it fits
      assign trial[i]  = {rem_src[i], bits_src[i][QUOT_W-1]};
      assign den_in[i] = den_src[i];

      always_comb begin
         if (trial[i] >= {1'b0, den_src[i]}) begin
            rem_in[i]  = DIVISOR_W'(trial[i] - {1'b0, den_src[i]});
            bits_in[i] = {bits_src[i][QUOT_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = trial[i][DIVISOR_W-1:0];
            bits_in[i] = {bits_src[i][QUOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in[i];
         bits_ff[i] <= bits_in[i];
         den_ff[i]  <= den_in[i];
      end
   end

   assign quotient = bits_ff[QUOT_W-1];

endmodule

`default_nettype wire

// ===== sv/rgb_to_hsl_converter.sv =====
// Module: top level of the pipelined RGB to HSL pixel converter.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                                      Transfer
// ---------  -----------------------------------------  ---------------------------
// request    start, busy, req_red/green/blue             start high, busy low
// response   rsp_strobe, rsp_hue/saturation/lightness    rsp_strobe high, one cycle
//
// One pixel may enter every clock; busy is always low. Each pixel passes through the
// capture register, three front stages (max/min and sector, numerators, hue wrap),
// 17 stages of the two restoring dividers (one quotient bit each, which sets the
// latency), and the output register.
// Reset clears only the valid bits; the datapath holds no state between pixels.
// The receiver cannot stall, so the pipeline never holds and nothing is dropped.

module rgb_to_hsl_converter
   import rgbhsl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              start,
   output logic              busy,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,

   output logic              rsp_strobe,
   output logic [HUE_W-1:0]  rsp_hue,
   output logic [FRAC_W-1:0] rsp_saturation,
   output logic [FRAC_W-1:0] rsp_lightness
);

   // the pipeline always advances
   assign busy = 1'b0;

   // ---------------------------------------------------------------- stage A
   // Capture the pixel on transfer.
   logic              valid_a_ff;
   logic [CHAN_W-1:0] red_a_ff, green_a_ff, blue_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start & ~busy;
      end
      red_a_ff   <= req_red;
      green_a_ff <= req_green;
      blue_a_ff  <= req_blue;
   end

   // ---------------------------------------------------------------- stage B
   // Find max and min, pick the hue sector (red tested first, then green)
   // and the signed channel difference that drives it.
   logic                     valid_b_ff;
   logic [CHAN_W-1:0]        hi_b_in, lo_b_in, hi_b_ff, lo_b_ff;
   sector_type               sector_b_in, sector_b_ff;
   logic signed [CHAN_W:0]   diff_b_in, diff_b_ff;
   logic signed [CHAN_W:0]   red_s, green_s, blue_s;

   assign red_s   = $signed({1'b0, red_a_ff});
   assign green_s = $signed({1'b0, green_a_ff});
   assign blue_s  = $signed({1'b0, blue_a_ff});

   always_comb begin
      hi_b_in = red_a_ff;
      lo_b_in = red_a_ff;
      if (green_a_ff > hi_b_in) hi_b_in = green_a_ff;
      if (blue_a_ff > hi_b_in)  hi_b_in = blue_a_ff;
      if (green_a_ff < lo_b_in) lo_b_in = green_a_ff;
      if (blue_a_ff < lo_b_in)  lo_b_in = blue_a_ff;

      if (hi_b_in == red_a_ff) begin
         sector_b_in = SECTOR_RED;
         diff_b_in   = green_s - blue_s;
      end else if (hi_b_in == green_a_ff) begin
         sector_b_in = SECTOR_GREEN;
         diff_b_in   = blue_s - red_s;
      end else begin
         sector_b_in = SECTOR_BLUE;
         diff_b_in   = red_s - green_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      hi_b_ff     <= hi_b_in;
      lo_b_ff     <= lo_b_in;
      sector_b_ff <= sector_b_in;
      diff_b_ff   <= diff_b_in;
   end

   // ---------------------------------------------------------------- stage C
   // Chroma, sum, raw hue numerator, saturation divisor and lightness.
   logic                     valid_c_ff;
   logic [CHAN_W-1:0]        chroma_c;
   logic [SUM_W-1:0]         sum_c;
   logic signed [NUM_W-1:0]  chroma_s, offset_c;
   logic signed [NUM_W-1:0]  num_c_in, num_c_ff;
   logic [CHAN_W-1:0]        chroma_c_ff;
   logic [SUM_W-1:0]         upper_c;
   logic [CHAN_W-1:0]        den_c_in, den_c_ff;
   logic [FRAC_W-1:0]        scaled_c, scaled_inc;
   logic [FRAC_W:0]          tail_c;
   logic [CHAN_W:0]          frac_c;
   logic [FRAC_W:0]          light_wide;
   logic [FRAC_W-1:0]        light_c_in, light_c_ff;

   assign chroma_c = hi_b_ff - lo_b_ff;
   assign sum_c    = {1'b0, hi_b_ff} + {1'b0, lo_b_ff};
   assign chroma_s = $signed(NUM_W'(chroma_c));

   always_comb begin
      case (sector_b_ff)
         SECTOR_RED:   offset_c = '0;
         SECTOR_GREEN: offset_c = HUE_OFS_GREEN;
         SECTOR_BLUE:  offset_c = HUE_OFS_BLUE;
         default:      offset_c = '0;
      endcase
   end

   assign num_c_in = NUM_W'(diff_b_ff) * HUE_SCALE + offset_c * chroma_s;

   // divisor 255 - |sum - 255| is the smaller of sum and 510 - sum
   assign upper_c  = SUM_TOP - sum_c;
   assign den_c_in = (sum_c <= SUM_MID) ? sum_c[CHAN_W-1:0] : upper_c[CHAN_W-1:0];

   // sum*65536/510 = 128*sum + floor(128*sum/255); the division by 255
   // uses the (x+1 + (x+1)>>8) >> 8 identity, exact over 16 bits
   assign scaled_c   = {sum_c, 7'b0};
   assign scaled_inc = scaled_c + 16'd1;
   assign tail_c     = {1'b0, scaled_inc} + {9'b0, scaled_inc[FRAC_W-1:CHAN_W]};
   assign frac_c     = tail_c[FRAC_W:CHAN_W];
   assign light_wide = {1'b0, scaled_c} + {8'b0, frac_c};
   assign light_c_in = light_wide[FRAC_W] ? FRAC_MAX : light_wide[FRAC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_b_ff;
      end
      num_c_ff    <= num_c_in;
      chroma_c_ff <= chroma_c;
      den_c_ff    <= den_c_in;
      light_c_ff  <= light_c_in;
   end

   // ---------------------------------------------------------------- stage D
   // Wrap a negative hue by a full turn and stage the divider operands.
   logic                     valid_d_ff;
   logic signed [NUM_W-1:0]  wrapped_d;
   logic [HUE_DVD_W-1:0]     hue_dvd_d_ff;
   logic [CHAN_W-1:0]        hue_den_d_ff;
   logic [SAT_DVD_W-1:0]     sat_dvd_d_ff;
   logic [CHAN_W-1:0]        sat_den_d_ff;
   side_type                 side_d_in, side_d_ff;

   assign wrapped_d = num_c_ff[NUM_W-1]
                      ? num_c_ff + HUE_FULL * $signed(NUM_W'(chroma_c_ff))
                      : num_c_ff;

   assign side_d_in.grey  = (chroma_c_ff == '0);
   assign side_d_in.light = light_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else begin
         valid_d_ff <= valid_c_ff;
      end
      hue_dvd_d_ff <= wrapped_d[HUE_DVD_W-1:0];
      hue_den_d_ff <= chroma_c_ff;
      sat_dvd_d_ff <= {chroma_c_ff, {FRAC_W{1'b0}}};
      sat_den_d_ff <= den_c_ff;
      side_d_ff    <= side_d_in;
   end

   // ---------------------------------------------------------------- dividers
   logic [QUOT_W-1:0] hue_quot, sat_quot;

   rgbhsl_div #(
      .DIVIDEND_W (HUE_DVD_W),
      .DIVISOR_W  (CHAN_W),
      .QUOT_W     (QUOT_W)
   ) u_hue_div (
      .clock    (clock),
      .dividend (hue_dvd_d_ff),
      .divisor  (hue_den_d_ff),
      .quotient (hue_quot)
   );

   rgbhsl_div #(
      .DIVIDEND_W (SAT_DVD_W),
      .DIVISOR_W  (CHAN_W),
      .QUOT_W     (QUOT_W)
   ) u_sat_div (
      .clock    (clock),
      .dividend (sat_dvd_d_ff),
      .divisor  (sat_den_d_ff),
      .quotient (sat_quot)
   );

   // Carry valid and side data alongside the divider stages.
   logic     valid_q_ff [QUOT_W];
   side_type side_q_ff  [QUOT_W];

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUOT_W; i++) begin
         if (reset) begin
            valid_q_ff[i] <= 1'b0;
         end else if (i == 0) begin
            valid_q_ff[i] <= valid_d_ff;
         end else begin
            valid_q_ff[i] <= valid_q_ff[i-1];
         end
         side_q_ff[i] <= (i == 0) ? side_d_ff : side_q_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- output
   // Zero both quotients for a grey pixel, clamp hue and saturation.
   logic              strobe_ff;
   logic [HUE_W-1:0]  hue_in, hue_ff;
   logic [FRAC_W-1:0] sat_in, sat_ff;
   logic [FRAC_W-1:0] light_ff;
   side_type          side_e;

   assign side_e = side_q_ff[QUOT_W-1];

   always_comb begin
      if (side_e.grey) begin
         hue_in = '0;
      end else if (hue_quot > QUOT_W'(HUE_MAX)) begin
         hue_in = HUE_MAX;
      end else begin
         hue_in = hue_quot[HUE_W-1:0];
      end

      if (side_e.grey) begin
         sat_in = '0;
      end else if (sat_quot[FRAC_W]) begin
         sat_in = FRAC_MAX;
      end else begin
         sat_in = sat_quot[FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid_q_ff[QUOT_W-1];
      end
      hue_ff   <= hue_in;
      sat_ff   <= sat_in;
      light_ff <= side_e.light;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_lightness  = light_ff;

endmodule

`default_nettype wire
